FILE: rtl/assert_macros.svh
// assertion helpers used by the rtl top module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge out of reset
`define EDAC_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// condition must never be seen out of reset
`define EDAC_NEVER(label, clk, rstn, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

FILE: rtl/h74edac_pkg.sv
package h74edac_pkg;

  localparam int unsigned ADDR_W   = 8;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CW_W     = 7;
  localparam int unsigned ENTRY_W  = 2 * CW_W;
  localparam int unsigned LIMIT_W  = 9;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  localparam logic [LIMIT_W-1:0] BYTES_IN_USE_RST = 9'd256;

  typedef logic [1:0] action_t;
  localparam action_t ACT_WRITE = 2'd0;
  localparam action_t ACT_READ  = 2'd1;
  localparam action_t ACT_RAW   = 2'd2;

  // register select bit of paddr (word index)
  localparam logic REG_BYTES_IN_USE = 1'b0;

  typedef logic [CW_W-1:0]    cw_t;
  typedef logic [ENTRY_W-1:0] entry_t;

  // p2 p1 p0 d3 d2 d1 d0
  function automatic cw_t encode_nibble(input logic [3:0] d);
    cw_t c;
    c[6]   = ^(d & 4'h7);
    c[5]   = ^(d & 4'hB);
    c[4]   = ^(d & 4'hD);
    c[3:0] = d;
    return c;
  endfunction

  function automatic cw_t flip_for_syndrome(input logic [2:0] syn);
    cw_t f;
    case (syn)
      3'd0:    f = 7'h00;
      3'd1:    f = 7'h10;
      3'd2:    f = 7'h20;
      3'd3:    f = 7'h08;
      3'd4:    f = 7'h40;
      3'd5:    f = 7'h04;
      3'd6:    f = 7'h02;
      default: f = 7'h01;
    endcase
    return f;
  endfunction

  function automatic logic [3:0] decode_codeword(input cw_t c);
    logic [2:0] syn;
    cw_t        fixed;
    syn[2] = ^(c & 7'h47);
    syn[1] = ^(c & 7'h2B);
    syn[0] = ^(c & 7'h1D);
    fixed  = c ^ flip_for_syndrome(syn);
    return fixed[3:0];
  endfunction

  function automatic entry_t encode_byte(input logic [BYTE_W-1:0] b);
    return {encode_nibble(b[7:4]), encode_nibble(b[3:0])};
  endfunction

  function automatic logic [BYTE_W-1:0] decode_entry(input entry_t e);
    return {decode_codeword(e[13:7]), decode_codeword(e[6:0])};
  endfunction

endpackage

FILE: rtl/hamming74_edac_byte_memory_top.sv
// channel  | direction | payload                                         | handshake
// in_      | request   | action, address, write_data, raw_codewords,     | in_valid / in_stall
//          |           | last_byte                                       |
// out_     | result    | read_data, status, last                         | out_valid / out_stall
// apb      | config    | bytes_in_use at word 0                          | psel/penable/pready
//
// two stages: registered codeword memory read, then correct, scrub write and load of the
// output register. one request per cycle sustained while out_stall is low.
// a request that reads the entry written in the same cycle takes the forwarded codewords.
// synchronous active-low reset clears control and sets bytes_in_use to 256; memory content
// is undefined until written. out_stall holds the output register, then stage one, then in_stall.
`include "assert_macros.svh"

module hamming74_edac_byte_memory_top #(
  parameter int DEPTH = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_action,
  input  logic [h74edac_pkg::ADDR_W-1:0]     in_address,
  input  logic [h74edac_pkg::BYTE_W-1:0]     in_write_data,
  input  logic [h74edac_pkg::ENTRY_W-1:0]    in_raw_codewords,
  input  logic                               in_last_byte,

  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [h74edac_pkg::BYTE_W-1:0]     out_read_data,
  output logic                               out_status,
  output logic                               out_last,

  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [h74edac_pkg::APB_AW-1:0]     paddr,
  input  logic [h74edac_pkg::APB_DW-1:0]     pwdata,
  output logic [h74edac_pkg::APB_DW-1:0]     prdata,
  output logic                               pready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [16:0] DEPTH_LIM = 17'(DEPTH);

  logic [h74edac_pkg::LIMIT_W-1:0] bytes_in_use_r;

  logic [h74edac_pkg::ENTRY_W-1:0] mem [DEPTH];
  logic [h74edac_pkg::ENTRY_W-1:0] mem_rd_r;
  logic                            mem_we;
  logic [AW-1:0]                   mem_wa;
  logic [h74edac_pkg::ENTRY_W-1:0] mem_wd;

  logic                            s1_valid_r;
  h74edac_pkg::action_t            s1_action_r;
  logic [AW-1:0]                   s1_index_r;
  logic                            s1_ok_r;
  logic [h74edac_pkg::BYTE_W-1:0]  s1_wdata_r;
  logic [h74edac_pkg::ENTRY_W-1:0] s1_raw_r;
  logic                            s1_last_r;

  logic                            fwd_hit_r;
  logic [h74edac_pkg::ENTRY_W-1:0] fwd_data_r;

  logic                            out_valid_r;
  logic [h74edac_pkg::BYTE_W-1:0]  out_read_data_r;
  logic                            out_status_r;
  logic                            out_last_r;

  logic                            accept;
  logic                            advance;
  logic                            in_range;
  logic [AW-1:0]                   in_index;
  logic [h74edac_pkg::ENTRY_W-1:0] s1_cw;
  logic [h74edac_pkg::BYTE_W-1:0]  s1_rdata;
  logic                            cfg_we;

  // config port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == h74edac_pkg::REG_BYTES_IN_USE);

  always_comb begin
    prdata = '0;
    if (paddr[2] == h74edac_pkg::REG_BYTES_IN_USE) begin
      prdata = {{(h74edac_pkg::APB_DW - h74edac_pkg::LIMIT_W){1'b0}}, bytes_in_use_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_in_use_r <= h74edac_pkg::BYTES_IN_USE_RST;
    end else if (cfg_we) begin
      bytes_in_use_r <= pwdata[h74edac_pkg::LIMIT_W-1:0];
    end
  end

  // handshake
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  assign in_index = AW'(in_address);
  assign in_range = ({1'b0, in_address} < bytes_in_use_r) && (17'(in_address) < DEPTH_LIM);

  // stage two: correct and scrub
  assign s1_cw    = fwd_hit_r ? fwd_data_r : mem_rd_r;
  assign s1_rdata = (s1_ok_r && (s1_action_r == h74edac_pkg::ACT_READ)) ?
                    h74edac_pkg::decode_entry(s1_cw) : '0;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = s1_index_r;
    mem_wd = s1_raw_r;
    if (advance && s1_ok_r) begin
      case (s1_action_r)
        h74edac_pkg::ACT_WRITE: begin
          mem_we = 1'b1;
          mem_wd = h74edac_pkg::encode_byte(s1_wdata_r);
        end
        h74edac_pkg::ACT_READ: begin
          mem_we = 1'b1;
          mem_wd = h74edac_pkg::encode_byte(s1_rdata);
        end
        h74edac_pkg::ACT_RAW: begin
          mem_we = 1'b1;
          mem_wd = s1_raw_r;
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end
  end

  // codeword memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (accept) begin
      mem_rd_r <= mem[in_index];
    end
  end

  // stage one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
      fwd_hit_r  <= mem_we && (mem_wa == in_index);
    end else if (advance) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action_r <= in_action;
      s1_index_r  <= in_index;
      s1_ok_r     <= in_range;
      s1_wdata_r  <= in_write_data;
      s1_raw_r    <= in_raw_codewords;
      s1_last_r   <= in_last_byte;
      fwd_data_r  <= mem_wd;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_read_data_r <= s1_rdata;
      out_status_r    <= !s1_ok_r;
      out_last_r      <= s1_last_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_status    = out_status_r;
  assign out_last      = out_last_r;

  `EDAC_NEVER(a_no_write_oor, clk, rst_n, mem_we && !s1_ok_r, "write to rejected address")
  `EDAC_ASSERT(a_adv_to_out, clk, rst_n, advance |=> out_valid_r, "result not registered")
  `EDAC_ASSERT(a_fwd_src, clk, rst_n, $past(accept) && fwd_hit_r |-> $past(mem_we), "forward without write")
  `EDAC_NEVER(a_oor_data, clk, rst_n, out_valid_r && out_status_r && (out_read_data_r != '0),
              "rejected request returned data")

endmodule
